@@ hw/rtl/ihex_pkg.sv @@
// Shared definitions for the Intel HEX record parser: result codes,
// character constants and the hex digit decoder.
// No dependencies.
package ihex_pkg;

    // Result kinds reported on the result channel.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EOF   = 2'd1;
    localparam logic [1:0] KIND_PARSE = 2'd2;
    localparam logic [1:0] KIND_RANGE = 2'd3;

    // Characters with a special meaning in the text stream.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // Record types.
    localparam logic [7:0] REC_DATA     = 8'd0;
    localparam logic [7:0] REC_EOF      = 8'd1;
    localparam logic [7:0] REC_EXT_SEG  = 8'd2;
    localparam logic [7:0] REC_START_SEG = 8'd3;
    localparam logic [7:0] REC_EXT_LIN  = 8'd4;
    localparam logic [7:0] REC_START_LIN = 8'd5;

    // Reset value of the image limit register (1 MiB).
    localparam logic [31:0] IMAGE_LIMIT_RESET = 32'h0010_0000;

    // Decoded hex digit.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII character as a hex digit (0-9, a-f, A-F).
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.value = 4'(c - 8'h37);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

@@ hw/rtl/intel_hex_record_parser.sv @@
// Intel HEX record parser: one text character in, at most one result out.
// Depends on ihex_pkg for result codes, constants and the hex decoder.
//
// The parser takes one character per clock cycle with no bubbles: an
// accepted character lands in an input register; once the result slot is
// free, a single combinational step updates the parse state and loads the
// result register, so a result follows its character through both registers. Results
// leave through a one-entry output register; when it is held by a stalled
// consumer the input stops after one more character. Data records give one
// result per payload byte with its absolute address; the end of file record
// or any error gives a final result, after which the block consumes input
// silently until reset. The image limit may be written only while idle.
module intel_hex_record_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_char,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [31:0] m_byte_address,
    output logic [7:0]  m_data_byte,
    output logic [31:0] m_image_end
);

    // Parse phases.
    localparam logic [2:0] PH_LINE_START = 3'd0;
    localparam logic [2:0] PH_SKIP       = 3'd1;
    localparam logic [2:0] PH_LEN        = 3'd2;
    localparam logic [2:0] PH_ADDR       = 3'd3;
    localparam logic [2:0] PH_TYPE       = 3'd4;
    localparam logic [2:0] PH_PAYLOAD    = 3'd5;
    localparam logic [2:0] PH_CHECK      = 3'd6;

    logic [31:0] image_limit_reg;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;

    logic [2:0]  phase_reg,          phase_next;
    logic [3:0]  nibble_high_reg,    nibble_high_next;
    logic        nibble_pending_reg, nibble_pending_next;
    logic [7:0]  record_length_reg,  record_length_next;
    logic [7:0]  bytes_done_reg,     bytes_done_next;
    logic [31:0] record_address_reg, record_address_next;
    logic [7:0]  record_type_reg,    record_type_next;
    logic [7:0]  running_sum_reg,    running_sum_next;
    logic [31:0] base_offset_reg,    base_offset_next;
    logic [31:0] high_water_reg,     high_water_next;
    logic        halted_reg,         halted_next;

    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [31:0] m_addr_reg;
    logic [7:0]  m_byte_reg;
    logic [31:0] m_end_reg;

    logic        out_free;
    logic        step;
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [31:0] res_addr;
    logic [7:0]  res_byte;

    ihex_pkg::hex_digit_t digit;
    logic [7:0]  byte_val;
    logic [7:0]  sum_with_byte;
    logic [31:0] rec_start;
    logic [31:0] rec_end;

    // Handshake: the step runs when a character waits and the result slot is free.
    assign out_free = !m_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Datapath helpers for the current character.
    assign digit         = ihex_pkg::hex_decode(in_char_reg);
    assign byte_val      = {nibble_high_reg, digit.value};
    assign sum_with_byte = running_sum_reg + byte_val;
    assign rec_start     = record_address_reg + base_offset_reg;
    assign rec_end       = rec_start + {24'd0, record_length_reg};

    // One parse step for the character in the input register.
    always_comb begin
        phase_next          = phase_reg;
        nibble_high_next    = nibble_high_reg;
        nibble_pending_next = nibble_pending_reg;
        record_length_next  = record_length_reg;
        bytes_done_next     = bytes_done_reg;
        record_address_next = record_address_reg;
        record_type_next    = record_type_reg;
        running_sum_next    = running_sum_reg;
        base_offset_next    = base_offset_reg;
        high_water_next     = high_water_reg;
        halted_next         = halted_reg;
        res_valid           = 1'b0;
        res_kind            = ihex_pkg::KIND_DATA;
        res_addr            = 32'd0;
        res_byte            = 8'd0;

        if (!halted_reg) begin
            case (phase_reg)
                PH_LINE_START: begin
                    if (in_char_reg == ihex_pkg::CHAR_COLON) begin
                        phase_next          = PH_LEN;
                        running_sum_next    = 8'd0;
                        nibble_pending_next = 1'b0;
                        bytes_done_next     = 8'd0;
                        record_address_next = 32'd0;
                    end else if (in_char_reg != ihex_pkg::CHAR_LF) begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_LEN, PH_ADDR, PH_TYPE, PH_PAYLOAD, PH_CHECK: begin
                    if (in_char_reg == ihex_pkg::CHAR_LF || !digit.valid) begin
                        // A short line or a stray character inside a record.
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res_kind    = ihex_pkg::KIND_PARSE;
                    end else if (!nibble_pending_reg) begin
                        nibble_high_next    = digit.value;
                        nibble_pending_next = 1'b1;
                    end else begin
                        nibble_pending_next = 1'b0;
                        case (phase_reg)
                            PH_LEN: begin
                                record_length_next = byte_val;
                                running_sum_next   = sum_with_byte;
                                bytes_done_next    = 8'd0;
                                phase_next         = PH_ADDR;
                            end
                            PH_ADDR: begin
                                record_address_next = {16'd0, record_address_reg[7:0], byte_val};
                                running_sum_next    = sum_with_byte;
                                bytes_done_next     = bytes_done_reg + 8'd1;
                                if (bytes_done_reg + 8'd1 >= 8'd2) begin
                                    phase_next = PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                record_type_next = byte_val;
                                running_sum_next = sum_with_byte;
                                bytes_done_next  = 8'd0;
                                case (byte_val)
                                    ihex_pkg::REC_DATA: begin
                                        record_address_next = rec_start;
                                        phase_next = (record_length_reg != 8'd0) ?
                                                     PH_PAYLOAD : PH_CHECK;
                                        // Track the image end and check the limit.
                                        if (rec_end > high_water_reg) begin
                                            high_water_next = rec_end;
                                            if (rec_end > image_limit_reg) begin
                                                halted_next = 1'b1;
                                                res_valid   = 1'b1;
                                                res_kind    = ihex_pkg::KIND_RANGE;
                                            end
                                        end
                                    end
                                    ihex_pkg::REC_EOF: begin
                                        halted_next = 1'b1;
                                        res_valid   = 1'b1;
                                        res_kind    = (record_length_reg != 8'd0) ?
                                                      ihex_pkg::KIND_PARSE :
                                                      ihex_pkg::KIND_EOF;
                                    end
                                    ihex_pkg::REC_EXT_SEG, ihex_pkg::REC_EXT_LIN: begin
                                        if (record_length_reg != 8'd2) begin
                                            halted_next = 1'b1;
                                            res_valid   = 1'b1;
                                            res_kind    = ihex_pkg::KIND_PARSE;
                                        end else begin
                                            record_address_next = 32'd0;
                                            phase_next          = PH_PAYLOAD;
                                        end
                                    end
                                    ihex_pkg::REC_START_SEG, ihex_pkg::REC_START_LIN: begin
                                        phase_next = (record_length_reg != 8'd0) ?
                                                     PH_PAYLOAD : PH_CHECK;
                                    end
                                    default: begin
                                        halted_next = 1'b1;
                                        res_valid   = 1'b1;
                                        res_kind    = ihex_pkg::KIND_PARSE;
                                    end
                                endcase
                            end
                            PH_PAYLOAD: begin
                                running_sum_next = sum_with_byte;
                                if (record_type_reg == ihex_pkg::REC_DATA) begin
                                    res_valid = 1'b1;
                                    res_kind  = ihex_pkg::KIND_DATA;
                                    res_addr  = record_address_reg + {24'd0, bytes_done_reg};
                                    res_byte  = byte_val;
                                end else if (record_type_reg == ihex_pkg::REC_EXT_SEG ||
                                             record_type_reg == ihex_pkg::REC_EXT_LIN) begin
                                    record_address_next =
                                        {16'd0, record_address_reg[7:0], byte_val};
                                end
                                bytes_done_next = bytes_done_reg + 8'd1;
                                // Last payload byte: commit an extended address.
                                if (bytes_done_reg + 8'd1 >= record_length_reg) begin
                                    if (record_type_reg == ihex_pkg::REC_EXT_SEG) begin
                                        base_offset_next =
                                            {12'd0, record_address_next[15:0], 4'd0};
                                    end else if (record_type_reg == ihex_pkg::REC_EXT_LIN) begin
                                        base_offset_next = {record_address_next[15:0], 16'd0};
                                    end
                                    phase_next = PH_CHECK;
                                end
                            end
                            PH_CHECK: begin
                                if (sum_with_byte != 8'd0) begin
                                    halted_next = 1'b1;
                                    res_valid   = 1'b1;
                                    res_kind    = ihex_pkg::KIND_PARSE;
                                end else begin
                                    phase_next = PH_SKIP;
                                end
                            end
                            default: begin
                                phase_next = PH_SKIP;
                            end
                        endcase
                    end
                end
                default: begin
                    // Skipping the rest of a line up to the newline.
                    phase_next = (in_char_reg == ihex_pkg::CHAR_LF) ? PH_LINE_START : PH_SKIP;
                end
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_limit_reg <= ihex_pkg::IMAGE_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            image_limit_reg <= cfg_wr_data;
        end
    end

    // Input register: holds one character until the step can run.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_text_char;
        end
    end

    // Parse state, updated once per consumed character.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_LINE_START;
            nibble_high_reg    <= 4'd0;
            nibble_pending_reg <= 1'b0;
            record_length_reg  <= 8'd0;
            bytes_done_reg     <= 8'd0;
            record_address_reg <= 32'd0;
            record_type_reg    <= 8'd0;
            running_sum_reg    <= 8'd0;
            base_offset_reg    <= 32'd0;
            high_water_reg     <= 32'd0;
            halted_reg         <= 1'b0;
        end else if (step) begin
            phase_reg          <= phase_next;
            nibble_high_reg    <= nibble_high_next;
            nibble_pending_reg <= nibble_pending_next;
            record_length_reg  <= record_length_next;
            bytes_done_reg     <= bytes_done_next;
            record_address_reg <= record_address_next;
            record_type_reg    <= record_type_next;
            running_sum_reg    <= running_sum_next;
            base_offset_reg    <= base_offset_next;
            high_water_reg     <= high_water_next;
            halted_reg         <= halted_next;
        end
    end

    // Result register: loaded whenever the slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            m_kind_reg <= res_kind;
            m_addr_reg <= res_addr;
            m_byte_reg <= res_byte;
            m_end_reg  <= high_water_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_byte_address = m_addr_reg;
    assign m_data_byte    = m_byte_reg;
    assign m_image_end    = m_end_reg;

    // Once halted, the parser stays halted until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("parser left the halted state without reset");

    // A character consumed while halted never produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && halted_reg) |=> !m_valid_reg)
        else $error("result produced after end of file or error");

    // Outside a record no half-read hex pair is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LINE_START || phase_reg == PH_SKIP) |-> !nibble_pending_reg)
        else $error("hex nibble pending outside a record");

    // Non-data results carry zero address and byte fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg != ihex_pkg::KIND_DATA)
            |-> (m_addr_reg == 32'd0 && m_byte_reg == 8'd0))
        else $error("non-data result carries address or data");

endmodule
